### rtl/core/ois_pkg.sv
// Shared constants, codes and controller/datapath bundles for the ordered integer set table.
// No dependencies; used by ois_ctrl, ois_dpath and ordered_integer_set_table.
package ois_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int ACT_W  = 2;
    localparam int ELEM_W = 32;
    localparam int STAT_W = 2;
    localparam int POS_W  = 4;
    localparam int OUT_DATA_W = 8;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_APPEND,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan;
        logic shift;
        logic append;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             scan_done;
        logic             scan_hit;
        logic             full;
        logic             shift_done;
        logic             out_busy;
        logic [CNT_W-1:0] count;
    } t_dp_status;

endpackage

### rtl/core/ois_dpath.sv
// Datapath: entry memory, scan/compaction pointer, fill count, result and output registers.
// Depends on ois_pkg; driven by ois_ctrl through t_dp_cmd.
module ois_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ois_pkg::t_dp_cmd              i_cmd,
    output ois_pkg::t_dp_status           o_status,
    input  logic [ois_pkg::ACT_W-1:0]     i_action,
    input  logic [ois_pkg::ELEM_W-1:0]    i_element,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [ois_pkg::STAT_W-1:0]    o_out_status,
    output logic [ois_pkg::POS_W-1:0]     o_out_pos
);

    logic [ois_pkg::ELEM_W-1:0] mem [ois_pkg::CAPACITY];

    logic [ois_pkg::ACT_W-1:0]  r_action;
    logic [ois_pkg::ELEM_W-1:0] r_element;
    logic [ois_pkg::CNT_W-1:0]  r_count;
    logic [ois_pkg::CNT_W-1:0]  r_ptr;
    logic                       r_rd_ok;
    logic [ois_pkg::IDX_W-1:0]  r_rd_addr;
    logic [ois_pkg::ELEM_W-1:0] r_rdata;
    logic [ois_pkg::STAT_W-1:0] r_res_status;
    logic [ois_pkg::POS_W-1:0]  r_res_pos;
    logic                       r_out_valid;
    logic [ois_pkg::STAT_W-1:0] r_out_status;
    logic [ois_pkg::POS_W-1:0]  r_out_pos;

    logic rd_en;
    logic hit;
    logic full;
    logic scan_done;
    logic shift_done;
    logic walking;

    always_comb begin
        walking    = i_cmd.scan | i_cmd.shift;
        rd_en      = r_ptr < r_count;
        hit        = r_rd_ok && (r_rdata == r_element);
        full       = r_count >= ois_pkg::CNT_W'(ois_pkg::CAPACITY);
        // scan ends on a match or once the last read has been compared
        scan_done  = hit || (!r_rd_ok && !rd_en);
        shift_done = !r_rd_ok && !rd_en;
    end

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            mem[r_count[ois_pkg::IDX_W-1:0]] <= r_element;
        end else if (i_cmd.shift && r_rd_ok) begin
            mem[r_rd_addr - ois_pkg::IDX_W'(1)] <= r_rdata;
        end
        if (walking && rd_en) begin
            r_rdata   <= mem[r_ptr[ois_pkg::IDX_W-1:0]];
            r_rd_addr <= r_ptr[ois_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ptr       <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_ptr   <= '0;
                r_rd_ok <= 1'b0;
            end else if (i_cmd.scan && hit) begin
                // compaction starts reading just above the match
                r_ptr   <= ois_pkg::CNT_W'(r_rd_addr) + ois_pkg::CNT_W'(1);
                r_rd_ok <= 1'b0;
            end else if (walking) begin
                r_rd_ok <= rd_en;
                if (rd_en) begin
                    r_ptr <= r_ptr + ois_pkg::CNT_W'(1);
                end
            end

            if (i_cmd.append) begin
                r_count <= r_count + ois_pkg::CNT_W'(1);
            end else if (i_cmd.shift && shift_done) begin
                r_count <= r_count - ois_pkg::CNT_W'(1);
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action  <= i_action;
            r_element <= i_element;
        end
        if (i_cmd.scan && scan_done) begin
            if (hit) begin
                r_res_status <= (r_action == ois_pkg::ACT_INSERT) ? ois_pkg::ST_MISS
                                                                  : ois_pkg::ST_OK;
                r_res_pos    <= ois_pkg::POS_W'(r_rd_addr);
            end else if (r_action == ois_pkg::ACT_INSERT) begin
                r_res_status <= full ? ois_pkg::ST_FULL : ois_pkg::ST_OK;
                r_res_pos    <= full ? '0 : ois_pkg::POS_W'(r_count);
            end else begin
                r_res_status <= ois_pkg::ST_MISS;
                r_res_pos    <= '0;
            end
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_pos    <= r_res_pos;
        end
    end

    always_comb begin
        o_status.act        = r_action;
        o_status.scan_done  = scan_done;
        o_status.scan_hit   = hit;
        o_status.full       = full;
        o_status.shift_done = shift_done;
        o_status.out_busy   = r_out_valid && !i_out_ready;
        o_status.count      = r_count;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_pos    = r_out_pos;

endmodule

### rtl/core/ois_ctrl.sv
// Controller state machine: accept, scan, compaction or append, then result hand-off.
// Depends on ois_pkg; drives ois_dpath through t_dp_cmd.
module ois_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ois_pkg::t_dp_status  i_status,
    output ois_pkg::t_dp_cmd     o_cmd
);

    ois_pkg::t_state r_state;
    ois_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ois_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ois_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ois_pkg::S_SEARCH;
            end
            ois_pkg::S_SEARCH: begin
                if (i_status.scan_done) begin
                    if (i_status.scan_hit && i_status.act == ois_pkg::ACT_REMOVE) begin
                        n_state = ois_pkg::S_SHIFT;
                    end else if (!i_status.scan_hit && i_status.act == ois_pkg::ACT_INSERT
                                 && !i_status.full) begin
                        n_state = ois_pkg::S_APPEND;
                    end else begin
                        n_state = ois_pkg::S_RESULT;
                    end
                end
            end
            ois_pkg::S_SHIFT: begin
                if (i_status.shift_done) n_state = ois_pkg::S_RESULT;
            end
            ois_pkg::S_APPEND: begin
                n_state = ois_pkg::S_RESULT;
            end
            ois_pkg::S_RESULT: begin
                if (!i_status.out_busy) n_state = ois_pkg::S_IDLE;
            end
            default: n_state = ois_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ois_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ois_pkg::S_SEARCH: o_cmd.scan   = 1'b1;
            ois_pkg::S_SHIFT:  o_cmd.shift  = 1'b1;
            ois_pkg::S_APPEND: o_cmd.append = 1'b1;
            ois_pkg::S_RESULT: o_cmd.load_out = !i_status.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

### rtl/core/ordered_integer_set_table.sv
// Ordered integer set table: up to 16 distinct 32-bit values kept in insertion order.
// Depends on ois_pkg, ois_ctrl and ois_dpath.
//
// Input stream: one beat per command. tuser carries the action (lookup, insert if
// absent, remove if present), tdata the signed 32-bit value. Output stream: one beat
// per command, tuser = status (done/found, absent/already present, full), tdata = position.
// One command is worked at a time; o_s_axis_tready is high only while the block waits.
// Each command is accepted, then scanned up to the count or to the match (one read per cycle
// through the single registered port); a remove that matched then compacts the entries
// above the match down by one, an insert that missed and found room writes at the end,
// and finally the result register is loaded.
// The result sits in an output register, so the next command is taken while it waits;
// if the receiver stalls and a second result is ready, the block holds it until the
// output register empties. Reset empties the table (count to zero) and the output.
// The entry memory is not cleared: only entries below the count are ever read.
module ordered_integer_set_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] element
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [3:0] position, [7:4] zero
    output logic [1:0]  o_m_axis_tuser   // [1:0] status
);

    ois_pkg::t_dp_cmd    cmd;
    ois_pkg::t_dp_status status;
    logic [ois_pkg::POS_W-1:0] out_pos;

    ois_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ois_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_action     (i_s_axis_tuser),
        .i_element    (i_s_axis_tdata),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_status (o_m_axis_tuser),
        .o_out_pos    (out_pos)
    );

    assign o_m_axis_tdata = {{(ois_pkg::OUT_DATA_W - ois_pkg::POS_W){1'b0}}, out_pos};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.count <= ois_pkg::CNT_W'(ois_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.append |=> status.count == $past(status.count) + ois_pkg::CNT_W'(1))
        else $error("append did not bump the count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> !o_s_axis_tready)
        else $error("input ready while a command is in work");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

### bench/tb.sv
// Self-checking bench for ordered_integer_set_table: stream driver, stream monitor and
// a cycle-free predictor of the set contents. Depends on ois_pkg and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ois_pkg::ACT_W-1:0]  act;
        logic [ois_pkg::ELEM_W-1:0] elem;
    } t_set_cmd;

    typedef struct packed {
        logic [ois_pkg::STAT_W-1:0] status;
        logic [ois_pkg::POS_W-1:0]  pos;
    } t_set_reply;

    localparam int RANDOM_CMDS = 1120;
    localparam int DRAIN_CYCLES = 48;
    // unused action code, behaves as a lookup
    localparam logic [ois_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    logic [31:0] cmd_data = '0;  // [31:0] element
    logic [1:0]  cmd_user = '0;  // [1:0] action
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [7:0]  rsp_data;       // [3:0] position, [7:4] zero
    logic [1:0]  rsp_user;       // [1:0] status

    ordered_integer_set_table i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (cmd_valid),
        .o_s_axis_tready (cmd_ready),
        .i_s_axis_tdata  (cmd_data),
        .i_s_axis_tuser  (cmd_user),
        .o_m_axis_tvalid (rsp_valid),
        .i_m_axis_tready (rsp_ready),
        .o_m_axis_tdata  (rsp_data),
        .o_m_axis_tuser  (rsp_user)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the table contents
    logic [ois_pkg::ELEM_W-1:0] shadow_vals [ois_pkg::CAPACITY];
    int                         shadow_size = 0;

    t_set_cmd   cmd_q [$];
    t_set_reply reply_q [$];
    int         n_total = 0;
    int         n_sent = 0;
    int         n_seen = 0;
    int         n_errors = 0;
    int         n_ok = 0;
    int         n_miss = 0;
    int         n_full = 0;
    int         n_compact = 0;
    int         peak_size = 0;

    function automatic t_set_reply apply_set_command(t_set_cmd c);
        t_set_reply r;
        int         hit_at;
        hit_at = -1;
        r.status = ois_pkg::ST_MISS;
        r.pos = '0;
        for (int i = 0; i < shadow_size; i++)
            if (hit_at < 0 && shadow_vals[i] == c.elem)
                hit_at = i;
        case (c.act)
            ois_pkg::ACT_INSERT: begin
                if (hit_at >= 0) begin
                    r.pos = hit_at[ois_pkg::POS_W-1:0];
                end else if (shadow_size >= ois_pkg::CAPACITY) begin
                    r.status = ois_pkg::ST_FULL;
                end else begin
                    shadow_vals[shadow_size] = c.elem;
                    r.pos = shadow_size[ois_pkg::POS_W-1:0];
                    r.status = ois_pkg::ST_OK;
                    shadow_size++;
                end
            end
            ois_pkg::ACT_REMOVE: begin
                if (hit_at >= 0) begin
                    if (hit_at < shadow_size - 1)
                        n_compact++;
                    for (int i = hit_at; i + 1 < shadow_size; i++)
                        shadow_vals[i] = shadow_vals[i + 1];
                    shadow_size--;
                    r.status = ois_pkg::ST_OK;
                    r.pos = hit_at[ois_pkg::POS_W-1:0];
                end
            end
            default: begin
                // lookup, and the spare code which behaves the same
                if (hit_at >= 0) begin
                    r.status = ois_pkg::ST_OK;
                    r.pos = hit_at[ois_pkg::POS_W-1:0];
                end
            end
        endcase
        if (shadow_size > peak_size)
            peak_size = shadow_size;
        case (r.status)
            ois_pkg::ST_OK:   n_ok++;
            ois_pkg::ST_FULL: n_full++;
            default: n_miss++;
        endcase
        return r;
    endfunction

    function automatic int unsigned idle_cycles(bit quiet);
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic push_cmd(logic [ois_pkg::ACT_W-1:0] act, logic [ois_pkg::ELEM_W-1:0] elem);
        t_set_cmd c;
        c.act = act;
        c.elem = elem;
        cmd_q.push_back(c);
        n_total++;
    endtask

    // ---------------- driver ----------------
    int unsigned send_wait = 0;
    bit          send_quiet = 1'b0;
    t_set_cmd    cur_cmd;

    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_valid <= 1'b0;
        end else begin
            if (cmd_valid && cmd_ready) begin
                reply_q.push_back(apply_set_command(cur_cmd));
                n_sent++;
                if (n_sent % 50 == 0)
                    send_quiet = ($urandom_range(0, 3) == 0);
                send_wait = idle_cycles(send_quiet);
            end
            if (!cmd_valid || cmd_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    cmd_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    cur_cmd = cmd_q.pop_front();
                    cmd_valid <= 1'b1;
                    cmd_data <= cur_cmd.elem;
                    cmd_user <= cur_cmd.act;
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int unsigned recv_wait = 0;
    bit          recv_quiet = 1'b0;
    t_set_reply  want;

    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                n_seen++;
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected result beat, status %0d tdata 0x%02h",
                             $time, rsp_user, rsp_data);
                    n_errors++;
                end else begin
                    want = reply_q.pop_front();
                    if (rsp_user !== want.status) begin
                        $display("%0t: result %0d status: expected %0d, actual %0d",
                                 $time, n_seen, want.status, rsp_user);
                        n_errors++;
                    end
                    if (rsp_data !== {4'b0000, want.pos}) begin
                        $display("%0t: result %0d tdata: expected 0x%02h, actual 0x%02h",
                                 $time, n_seen, {4'b0000, want.pos}, rsp_data);
                        n_errors++;
                    end
                end
                if (n_seen % 50 == 0)
                    recv_quiet = ($urandom_range(0, 3) == 0);
                recv_wait = idle_cycles(recv_quiet);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        logic [ois_pkg::ELEM_W-1:0] pool [24];
        int                         pool_len;
        int                         made;
        int unsigned                pick;
        logic [ois_pkg::ACT_W-1:0]  act;
        logic [ois_pkg::ELEM_W-1:0] elem;

        // directed: empty table, extremes, duplicates, spare code, compaction, full table
        push_cmd(ois_pkg::ACT_LOOKUP, 32'h8000_0000);
        push_cmd(ois_pkg::ACT_REMOVE, 32'h0000_0005);
        push_cmd(ois_pkg::ACT_INSERT, 32'h8000_0000);
        push_cmd(ois_pkg::ACT_INSERT, 32'h7FFF_FFFF);
        push_cmd(ois_pkg::ACT_INSERT, 32'h0000_0000);
        push_cmd(ois_pkg::ACT_INSERT, 32'hFFFF_FFFF);
        push_cmd(ois_pkg::ACT_INSERT, 32'h7FFF_FFFF);
        push_cmd(ois_pkg::ACT_LOOKUP, 32'hFFFF_FFFF);
        push_cmd(ACT_SPARE, 32'h0000_0000);
        push_cmd(ois_pkg::ACT_REMOVE, 32'h7FFF_FFFF);
        push_cmd(ois_pkg::ACT_LOOKUP, 32'hFFFF_FFFF);
        push_cmd(ois_pkg::ACT_REMOVE, 32'hFFFF_FFFF);
        for (int i = 0; i < ois_pkg::CAPACITY - 2; i++)
            push_cmd(ois_pkg::ACT_INSERT,
                     (i % 2) ? (32'hAAAA_0000 | i) : (32'h5555_0000 | i));
        push_cmd(ois_pkg::ACT_INSERT, 32'h1234_5678);
        push_cmd(ois_pkg::ACT_REMOVE, 32'h8000_0000);
        push_cmd(ois_pkg::ACT_LOOKUP, 32'hAAAA_000D);

        // random: short-lived value pools so inserts collide, the table fills and drains
        made = 0;
        while (made < RANDOM_CMDS) begin
            pool_len = $urandom_range(2, 24);
            for (int i = 0; i < pool_len; i++) begin
                case ($urandom_range(0, 7))
                    0: pool[i] = 32'h8000_0000;
                    1: pool[i] = 32'h7FFF_FFFF;
                    2: pool[i] = $urandom_range(0, 3);
                    3: pool[i] = 32'hFFFF_FFFF;
                    default: pool[i] = $urandom;
                endcase
            end
            for (int k = 0; k < 100 && made < RANDOM_CMDS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 42)
                    act = ois_pkg::ACT_INSERT;
                else if (pick < 70)
                    act = ois_pkg::ACT_REMOVE;
                else if (pick < 95)
                    act = ois_pkg::ACT_LOOKUP;
                else
                    act = ACT_SPARE;
                if ($urandom_range(0, 99) < 85)
                    elem = pool[$urandom_range(0, pool_len - 1)];
                else
                    elem = $urandom;
                push_cmd(act, elem);
                made++;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_total)
            @(posedge clk);
        while (reply_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands: %0d done or found, %0d absent or duplicate, %0d full rejects",
                 n_total, n_ok, n_miss, n_full);
        $display("Removes that compacted later entries: %0d, peak occupancy %0d of %0d",
                 n_compact, peak_size, ois_pkg::CAPACITY);
        if (n_errors == 0 && reply_q.size() == 0) begin
            $display("** ordered_integer_set_table: PASSED **");
        end else begin
            $display("** ordered_integer_set_table: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d of %0d commands sent, %0d results pending",
                 $time, n_sent, n_total, reply_q.size());
        $display("** ordered_integer_set_table: FAILED **");
        $finish;
    end

endmodule
